[hdl/dchs_pkg.sv]
package dchs_pkg;

    // quotient bits of 1048576 / block size, one per divider stage
    localparam int unsigned DIV_STEPS = 21;

    localparam logic [31:0] BYTES_PER_MB = 32'd1048576;

    // extended translation needs more than this many megabytes
    localparam logic [10:0] MB_THRESHOLD = 11'd1024;

    localparam logic [7:0] EXT_HEADS   = 8'd255;
    localparam logic [5:0] EXT_SECTORS = 6'd63;
    localparam logic [7:0] STD_HEADS   = 8'd64;
    localparam logic [5:0] STD_SECTORS = 6'd32;

    // 64 * 32 = 2^11, so the standard cylinder count is a shift
    localparam int unsigned STD_SHIFT = 11;

    // 255 * 63, divided by reciprocal multiply plus one correction step
    localparam logic [13:0] EXT_DIV     = 14'd16065;
    localparam logic [31:0] RECIP_M     = 32'd2190125869;
    localparam int unsigned RECIP_SHIFT = 45;

    typedef struct packed {
        logic [20:0] divisor;
        logic [20:0] rem;
        logic [20:0] quo;
        logic [31:0] vol;
        logic        ext;
        logic        err;
        logic [20:0] cyl_std;
        logic [18:0] cyl_ext;
    } dchs_item_t;

    typedef struct packed {
        logic        status;
        logic [20:0] cylinders;
        logic [5:0]  sectors_per_track;
        logic [7:0]  heads;
    } dchs_result_t;

endpackage

[hdl/dchs_front.sv]
module dchs_front
    import dchs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_block_bytes,
    input  logic [31:0] in_volume_blocks,
    input  logic        in_extended,
    output logic        out_valid,
    input  logic        out_ready,
    output dchs_item_t  out_item
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        r1, r2, r3, r4;

    logic [31:0] vol1_reg, vol2_reg, vol3_reg;
    logic [20:0] div1_reg, div2_reg, div3_reg;
    logic        ext1_reg, ext2_reg, ext3_reg;
    logic        err1_reg, err2_reg, err3_reg;
    logic [63:0] prod2_reg;
    logic [18:0] q0_3_reg;
    logic [31:0] qd3_reg;
    dchs_item_t  item4_reg;

    logic        err_next;
    logic [63:0] prod_next;
    logic [18:0] q0_next;
    logic [32:0] qd_full;
    logic [31:0] rem_ext;
    dchs_item_t  item_next;

    assign r4 = !v4_reg || out_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v4_reg;
    assign out_item  = item4_reg;

    always_comb begin
        err_next  = (in_block_bytes == 32'd0) || (in_block_bytes > BYTES_PER_MB);
        prod_next = 64'(vol1_reg) * 64'(RECIP_M);
        q0_next   = prod2_reg[RECIP_SHIFT +: 19];
        qd_full   = 33'(q0_next) * 33'(EXT_DIV);
        rem_ext   = vol3_reg - qd3_reg;

        item_next         = '0;
        item_next.divisor = div3_reg;
        item_next.vol     = vol3_reg;
        item_next.ext     = ext3_reg;
        item_next.err     = err3_reg;
        item_next.cyl_std = vol3_reg[31:STD_SHIFT];
        // reciprocal estimate is at most one low
        item_next.cyl_ext = (rem_ext >= 32'(EXT_DIV)) ? q0_3_reg + 19'd1 : q0_3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            vol1_reg <= in_volume_blocks;
            div1_reg <= in_block_bytes[20:0];
            ext1_reg <= in_extended;
            err1_reg <= err_next;
        end
        if (r2 && v1_reg) begin
            vol2_reg  <= vol1_reg;
            div2_reg  <= div1_reg;
            ext2_reg  <= ext1_reg;
            err2_reg  <= err1_reg;
            prod2_reg <= prod_next;
        end
        if (r3 && v2_reg) begin
            vol3_reg <= vol2_reg;
            div3_reg <= div2_reg;
            ext3_reg <= ext2_reg;
            err3_reg <= err2_reg;
            q0_3_reg <= q0_next;
            qd3_reg  <= qd_full[31:0];
        end
        if (r4 && v3_reg) begin
            item4_reg <= item_next;
        end
    end

endmodule

[hdl/dchs_div_stage.sv]
module dchs_div_stage
    import dchs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       dvd_bit,
    input  logic       in_valid,
    output logic       in_ready,
    input  dchs_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output dchs_item_t out_item
);

    logic       valid_reg;
    dchs_item_t item_reg;
    dchs_item_t item_next;
    logic [21:0] partial;
    logic [21:0] diff;
    logic        fits;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        partial   = {in_item.rem, dvd_bit};
        diff      = partial - {1'b0, in_item.divisor};
        fits      = partial >= {1'b0, in_item.divisor};
        item_next = in_item;
        item_next.rem = fits ? diff[20:0] : partial[20:0];
        item_next.quo = {in_item.quo[19:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

[hdl/dchs_back.sv]
module dchs_back
    import dchs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  dchs_item_t   in_item,
    output logic         out_valid,
    input  logic         out_ready,
    output dchs_result_t out_result
);

    logic         valid_reg;
    dchs_result_t result_reg;
    dchs_result_t result_next;
    logic [31:0]  limit;
    logic         use_ext;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // vol / per_mb > 1024 exactly when vol >= 1025 * per_mb
    always_comb begin
        limit   = {1'b0, in_item.quo, 10'd0} + 32'(in_item.quo);
        use_ext = in_item.ext && (in_item.vol >= limit);
        result_next = '0;
        result_next.status = in_item.err;
        if (!in_item.err) begin
            if (use_ext) begin
                result_next.heads             = EXT_HEADS;
                result_next.sectors_per_track = EXT_SECTORS;
                result_next.cylinders         = 21'(in_item.cyl_ext);
            end else begin
                result_next.heads             = STD_HEADS;
                result_next.sectors_per_track = STD_SECTORS;
                result_next.cylinders         = in_item.cyl_std;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

endmodule

[hdl/disk_chs_geometry_calc.sv]
// CHS geometry from block size and volume size.
//
// input word: s_tdata carries block_bytes and volume_blocks, s_tuser the
// extended translation flag. result word: m_tdata carries heads, sectors per
// track and cylinders, m_tuser the error status (bad block size, all fields 0).
//
// the pipeline has 26 register stages: four front stages (input register,
// reciprocal multiply, correction multiply, correction), 21 restoring
// divider stages that form 1048576 / block size one quotient bit each, and
// the output register that picks the geometry.
// throughput is one word per cycle while m_tready is high; every stage takes
// a new word whenever it is empty or its successor moves, so back-to-back
// words flow with no gaps.
// reset (aresetn low, synchronous) empties all stages; words in flight are
// dropped. when m_tready is low the output word holds, the stages behind it
// fill up bubble by bubble, and s_tready falls only once all 26 are full.
module disk_chs_geometry_calc
    import dchs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // block_bytes[31:0], volume_blocks[63:32]
    input  logic        s_tuser,   // extended
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // heads[7:0], sectors_per_track[13:8], cylinders[34:14]
    output logic        m_tuser    // status
);

    logic         node_valid [DIV_STEPS+1];
    logic         node_ready [DIV_STEPS+1];
    dchs_item_t   node_item  [DIV_STEPS+1];
    dchs_result_t result;

    dchs_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_block_bytes   (s_tdata[31:0]),
        .in_volume_blocks (s_tdata[63:32]),
        .in_extended      (s_tuser),
        .out_valid        (node_valid[0]),
        .out_ready        (node_ready[0]),
        .out_item         (node_item[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        // dividend 2^20 has its only set bit in the first step
        dchs_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .dvd_bit   (i == 0),
            .in_valid  (node_valid[i]),
            .in_ready  (node_ready[i]),
            .in_item   (node_item[i]),
            .out_valid (node_valid[i+1]),
            .out_ready (node_ready[i+1]),
            .out_item  (node_item[i+1])
        );
    end

    dchs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (node_valid[DIV_STEPS]),
        .in_ready   (node_ready[DIV_STEPS]),
        .in_item    (node_item[DIV_STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {5'd0, result.cylinders, result.sectors_per_track, result.heads};
    assign m_tuser = result.status;

endmodule

[hdl/dchs_checker.sv]
module dchs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // error words carry no geometry
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 40'd0)
        else $error("error word with nonzero geometry");

    // good words carry one of the two translations
    a_geom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (m_tdata[7:0] == 8'd64 && m_tdata[13:8] == 6'd32) ||
            (m_tdata[7:0] == 8'd255 && m_tdata[13:8] == 6'd63))
        else $error("bad heads/sectors pair");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    // a waiting input word stays put until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("stalled input word changed");

endmodule

bind disk_chs_geometry_calc dchs_checker u_dchs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
